@@ hdl/gbn_pkg.sv @@
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and codes of the go-back-N sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int unsigned LEN_W  = 13;  // internal segment length, bounded by the window
  localparam int unsigned CIDX_W = 2;

  typedef logic [2:0] code_t;

  // operation codes
  localparam code_t OP_START = 3'd0;
  localparam code_t OP_TICK  = 3'd1;
  localparam code_t OP_ACK   = 3'd2;
  localparam code_t OP_FIN   = 3'd3;
  localparam code_t OP_OTHER = 3'd4;
  localparam code_t OP_RTO   = 3'd5;

  // result kinds
  localparam code_t KIND_SEND    = 3'd0;
  localparam code_t KIND_DONE    = 3'd1;
  localparam code_t KIND_CLOSED  = 3'd2;
  localparam code_t KIND_GAVE_UP = 3'd3;
  localparam code_t KIND_DROPPED = 3'd4;
  localparam code_t KIND_ACCEPT  = 3'd5;
  localparam code_t KIND_NONE    = 3'd6;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_TOTAL_LENGTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WINDOW_BYTES  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;
  localparam logic [CIDX_W-1:0] REG_MAX_IDLE      = 2'd3;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_SENDING  = 2'd1,
    PH_FINISHED = 2'd2
  } phase_e;

  typedef struct packed {
    logic  latch;       // take the input word
    logic  restart;     // clear transfer state, enter sending
    logic  rewind;      // timeout: free all slots, resend from acked point
    logic  scan_clr;
    logic  scan_inc;
    logic  ack_free;    // free scanned slot if its sequence is covered
    logic  ack_update;
    logic  rto_inc;
    logic  finish;
    logic  len_load;
    logic  push;
    code_t kind;
    logic  flush;
  } gbn_cmd_t;

  typedef struct packed {
    code_t op;
    logic  sending;
    logic  drop_ack;
    logic  tick_hit;
    logic  scan_last;
    logic  done_cond;
    logic  idle_hit;
    logic  fill_ok;
    logic  can_push;
    logic  can_flush;
  } gbn_sts_t;

endpackage

@@ hdl/gbn_dp.sv @@
// ----------------------------------------------------------------------------
// gbn_dp
// Datapath: configuration, counters, slot ring, segment math and result queue.
// ----------------------------------------------------------------------------
module gbn_dp import gbn_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = 8,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic [2:0]        operation_i,
  input  logic [31:0]       ack_number_i,
  input  gbn_cmd_t          cmd_i,
  output gbn_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        kind_o,
  output logic [31:0]       segment_offset_o,
  output logic [10:0]       segment_length_o,
  output logic [31:0]       sequence_number_o,
  output logic              end_of_file_o,
  output logic              last_result_o
);

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

  typedef struct packed {
    code_t       kind;
    logic [31:0] off;
    logic [10:0] len;
    logic [31:0] seq;
    logic        eof;
  } res_t;

  logic [31:0]           total_q;
  logic [12:0]           window_q;
  logic [15:0]           timeout_q;
  logic [15:0]           max_idle_q;
  code_t                 op_q;
  logic [31:0]           ack_q;
  logic [31:0]           acked_q;
  logic [LEN_W-1:0]      outst_q;
  logic [31:0]           prev_q;
  logic [15:0]           idle_q;
  logic [SLOT_COUNT-1:0] free_q;
  logic [SLOT_W-1:0]     wslot_q;
  logic [31:0]           tick_q;
  phase_e                phase_q;
  logic [SLOT_W-1:0]     scan_q;
  logic [31:0]           rd_seq_q;
  logic [31:0]           rd_tick_q;
  logic [LEN_W-1:0]      len_q;
  logic [31:0]           off_q;
  logic                  pend_v_q;
  res_t                  pend_q;
  logic                  out_v_q;
  res_t                  out_q;
  logic                  last_q;

  logic [31:0] mem_seq  [SLOT_COUNT];
  logic [31:0] mem_tick [SLOT_COUNT];

  logic [32:0]      sum;
  logic [31:0]      avail;
  logic [31:0]      remain;
  logic [31:0]      len_a;
  logic [31:0]      len_b;
  logic [31:0]      seq;
  logic             scan_busy;
  res_t             new_res;

  assign sum    = {1'b0, acked_q} + 33'(outst_q);
  assign avail  = 32'(window_q - 13'(outst_q));
  assign remain = total_q - sum[31:0];
  assign len_a  = (avail > 32'(MAX_PAYLOAD)) ? 32'(MAX_PAYLOAD) : avail;
  assign len_b  = (len_a > remain) ? remain : len_a;
  assign seq    = off_q + 32'(len_q);
  assign scan_busy = !free_q[scan_q];

  always_comb begin
    new_res = '0;
    new_res.kind = cmd_i.kind;
    if (cmd_i.kind == KIND_SEND) begin
      new_res.off = off_q;
      new_res.len = len_q[10:0];
      new_res.seq = seq;
      new_res.eof = (seq >= total_q);
    end
  end

  always_comb begin
    sts_o.op        = op_q;
    sts_o.sending   = (phase_q == PH_SENDING);
    sts_o.drop_ack  = ({1'b0, ack_q} > sum) || (ack_q < prev_q);
    sts_o.tick_hit  = scan_busy && ((tick_q - rd_tick_q) > {16'd0, timeout_q});
    sts_o.scan_last = (scan_q == SLOT_LAST);
    sts_o.done_cond = (acked_q >= total_q) && (acked_q != '0) && (total_q != '0);
    sts_o.idle_hit  = (idle_q == max_idle_q);
    sts_o.fill_ok   = (sum < {1'b0, total_q}) && (13'(outst_q) < window_q)
                      && free_q[wslot_q];
    sts_o.can_push  = !pend_v_q || !out_v_q || !out_stall_i;
    sts_o.can_flush = !out_v_q || !out_stall_i;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      window_q   <= 13'd4096;
      timeout_q  <= 16'd500;
      max_idle_q <= 16'd10;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TOTAL_LENGTH:  total_q    <= cfg_data_i;
        REG_WINDOW_BYTES:  window_q   <= cfg_data_i[12:0];
        REG_TIMEOUT_TICKS: timeout_q  <= cfg_data_i[15:0];
        REG_MAX_IDLE:      max_idle_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // slot ring memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && cmd_i.kind == KIND_SEND) begin
      mem_seq[wslot_q]  <= seq;
      mem_tick[wslot_q] <= tick_q;
    end
    rd_seq_q  <= mem_seq[scan_q];
    rd_tick_q <= mem_tick[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      ack_q <= ack_number_i;
    end
    if (cmd_i.len_load) begin
      len_q <= len_b[LEN_W-1:0];
      off_q <= sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q <= '0;
      outst_q <= '0;
      prev_q  <= '0;
      idle_q  <= '0;
      free_q  <= '1;
      wslot_q <= '0;
      tick_q  <= '0;
      phase_q <= PH_IDLE;
      scan_q  <= '0;
    end else begin
      if (cmd_i.latch && operation_i == OP_TICK) tick_q <= tick_q + 32'd1;
      if (cmd_i.restart) begin
        acked_q <= '0;
        outst_q <= '0;
        prev_q  <= '0;
        idle_q  <= '0;
        free_q  <= '1;
        wslot_q <= '0;
        phase_q <= PH_SENDING;
      end
      if (cmd_i.rewind) begin
        outst_q <= '0;
        free_q  <= '1;
        wslot_q <= '0;
      end
      if (cmd_i.scan_clr) scan_q <= '0;
      else if (cmd_i.scan_inc) scan_q <= scan_q + SLOT_W'(1);
      if (cmd_i.ack_free && scan_busy && rd_seq_q <= ack_q) free_q[scan_q] <= 1'b1;
      if (cmd_i.ack_update) begin
        outst_q <= outst_q - LEN_W'(ack_q - prev_q);
        acked_q <= ack_q;
        prev_q  <= ack_q;
        idle_q  <= '0;
      end
      if (cmd_i.rto_inc) idle_q <= idle_q + 16'd1;
      if (cmd_i.finish) phase_q <= PH_FINISHED;
      if (cmd_i.push && cmd_i.kind == KIND_SEND) begin
        outst_q         <= outst_q + len_q;
        free_q[wslot_q] <= 1'b0;
        wslot_q         <= (wslot_q == SLOT_LAST) ? '0 : wslot_q + SLOT_W'(1);
      end
    end
  end

  // one result held back until the next one shows whether it is the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (cmd_i.push) begin
        pend_v_q <= 1'b1;
        if (pend_v_q) out_v_q <= 1'b1;
      end
      if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
        out_v_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_q <= new_res;
      if (pend_v_q) begin
        out_q  <= pend_q;
        last_q <= 1'b0;
      end
    end
    if (cmd_i.flush) begin
      if (pend_v_q) begin
        out_q <= pend_q;
      end else begin
        out_q <= '{kind: KIND_NONE, default: '0};
      end
      last_q <= 1'b1;
    end
  end

  assign out_valid_o       = out_v_q;
  assign kind_o            = out_q.kind;
  assign segment_offset_o  = out_q.off;
  assign segment_length_o  = out_q.len;
  assign sequence_number_o = out_q.seq;
  assign end_of_file_o     = out_q.eof;
  assign last_result_o     = last_q;

endmodule

@@ hdl/gbn_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: decodes an event and steps the datapath through scans and fills.
// ----------------------------------------------------------------------------
module gbn_ctrl import gbn_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  gbn_sts_t sts_i,
  output gbn_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_DECODE  = 12'b0000_0000_0010,
    S_TRD     = 12'b0000_0000_0100,
    S_TCHK    = 12'b0000_0000_1000,
    S_ARD     = 12'b0000_0001_0000,
    S_ACHK    = 12'b0000_0010_0000,
    S_AUPD    = 12'b0000_0100_0000,
    S_ADONE   = 12'b0000_1000_0000,
    S_IDLECHK = 12'b0001_0000_0000,
    S_FCHK    = 12'b0010_0000_0000,
    S_FEMIT   = 12'b0100_0000_0000,
    S_FLUSH   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.scan_clr = 1'b1;
        if (sts_i.op == OP_START) begin
          cmd_o.restart = 1'b1;
          state_d       = S_FCHK;
        end else if (!sts_i.sending) begin
          state_d = S_FLUSH;
        end else begin
          case (sts_i.op)
            OP_TICK: state_d = S_TRD;
            OP_ACK: begin
              if (sts_i.drop_ack) begin
                cmd_o.push = 1'b1;
                cmd_o.kind = KIND_DROPPED;
                state_d    = S_FLUSH;
              end else begin
                state_d = S_ARD;
              end
            end
            OP_FIN: begin
              cmd_o.finish = 1'b1;
              cmd_o.push   = 1'b1;
              cmd_o.kind   = KIND_CLOSED;
              state_d      = S_FLUSH;
            end
            OP_RTO: begin
              cmd_o.rto_inc = 1'b1;
              state_d       = S_IDLECHK;
            end
            default: state_d = S_FLUSH;
          endcase
        end
      end
      S_TRD: state_d = S_TCHK;
      S_TCHK: begin
        // lowest timed-out slot rewinds the whole window
        if (sts_i.tick_hit) begin
          cmd_o.rewind = 1'b1;
          state_d      = S_FCHK;
        end else if (sts_i.scan_last) begin
          state_d = S_FLUSH;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_TRD;
        end
      end
      S_ARD: state_d = S_ACHK;
      S_ACHK: begin
        cmd_o.ack_free = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_AUPD;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = S_ARD;
        end
      end
      S_AUPD: begin
        cmd_o.ack_update = 1'b1;
        cmd_o.push       = 1'b1;
        cmd_o.kind       = KIND_ACCEPT;
        state_d          = S_ADONE;
      end
      S_ADONE: begin
        if (!sts_i.done_cond) begin
          state_d = S_FCHK;
        end else if (sts_i.can_push) begin
          cmd_o.finish = 1'b1;
          cmd_o.push   = 1'b1;
          cmd_o.kind   = KIND_DONE;
          state_d      = S_FLUSH;
        end
      end
      S_IDLECHK: begin
        if (sts_i.idle_hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.push   = 1'b1;
          cmd_o.kind   = KIND_GAVE_UP;
        end
        state_d = S_FLUSH;
      end
      S_FCHK: begin
        if (sts_i.fill_ok) begin
          cmd_o.len_load = 1'b1;
          state_d        = S_FEMIT;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FEMIT: begin
        if (sts_i.can_push) begin
          cmd_o.push = 1'b1;
          cmd_o.kind = KIND_SEND;
          state_d    = S_FCHK;
        end
      end
      S_FLUSH: begin
        if (sts_i.can_flush) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

@@ hdl/go_back_n_sender_window.sv @@
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Byte-based go-back-N sender window: one event word in, a burst of results out.
// ----------------------------------------------------------------------------
// One event word is taken at a time; the next is taken once the last result of
// the current one has entered the output register. A tick or an accepted ACK walks
// the slot ring through the registered read port of the slot memories before any
// segments are sent. Output stall delays the sequencer on a push only when two
// results are already queued, and on the flush whenever the output is held.
// ----------------------------------------------------------------------------
module go_back_n_sender_window import gbn_pkg::*; #(
  parameter int unsigned SLOT_COUNT  = 8,
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        operation_i,
  input  logic [31:0]       ack_number_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        kind_o,
  output logic [31:0]       segment_offset_o,
  output logic [10:0]       segment_length_o,
  output logic [31:0]       sequence_number_o,
  output logic              end_of_file_o,
  output logic              last_result_o
);

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gbn_dp #(
    .SLOT_COUNT  (SLOT_COUNT),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .operation_i       (operation_i),
    .ack_number_i      (ack_number_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .kind_o            (kind_o),
    .segment_offset_o  (segment_offset_o),
    .segment_length_o  (segment_length_o),
    .sequence_number_o (sequence_number_o),
    .end_of_file_o     (end_of_file_o),
    .last_result_o     (last_result_o)
  );

endmodule

@@ sim/tb_go_back_n_sender_window.sv @@
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_window
// Self-checking bench for the go-back-N sender window. A scoreboard class
// predicts the result words of every accepted event word from its own copy
// of the window state. Directed events run first, then random transfers.
// Both channels idle and stall at random, and the monitor compares each
// result word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_go_back_n_sender_window import gbn_pkg::*;;

  localparam int unsigned SLOTS   = 8;
  localparam int unsigned PAYLOAD = 1024;
  localparam int unsigned DRAIN   = 60;

  typedef struct packed {
    code_t       kind;
    logic [31:0] offset;
    logic [10:0] length;
    logic [31:0] seq;
    logic        eof;
    logic        last;
  } result_t;

  class segment_scoreboard;
    logic [31:0] total_len;
    logic [12:0] window;
    logic [15:0] timeout;
    logic [15:0] max_idle;
    logic [31:0] acked;
    logic [31:0] in_flight;
    logic [31:0] prev_ack;
    logic [15:0] idle_cnt;
    logic        free_slot [SLOTS];
    logic [31:0] slot_seq  [SLOTS];
    logic [31:0] slot_tick [SLOTS];
    logic [2:0]  wr_slot;
    logic [31:0] ticks;
    phase_e      phase;
    result_t     expected_words[$];
    int          mismatches;

    function new();
      total_len  = '0;
      window     = 13'd4096;
      timeout    = 16'd500;
      max_idle   = 16'd10;
      ticks      = '0;
      phase      = PH_IDLE;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      acked     = '0;
      in_flight = '0;
      prev_ack  = '0;
      idle_cnt  = '0;
      wr_slot   = '0;
      for (int i = 0; i < SLOTS; i++) begin
        free_slot[i] = 1'b1;
        slot_seq[i]  = '0;
        slot_tick[i] = '0;
      end
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_TOTAL_LENGTH:  total_len = data;
        REG_WINDOW_BYTES:  window    = data[12:0];
        REG_TIMEOUT_TICKS: timeout   = data[15:0];
        default:           max_idle  = data[15:0];
      endcase
    endfunction

    function void push(code_t kind, logic [31:0] off, logic [31:0] len,
                       logic [31:0] seq, logic eof);
      result_t w;
      w.kind   = kind;
      w.offset = off;
      w.length = len[10:0];
      w.seq    = seq;
      w.eof    = eof;
      w.last   = 1'b0;
      expected_words.push_back(w);
    endfunction

    function void fill_window();
      logic [31:0] off;
      logic [31:0] len;
      while ({1'b0, acked} + {1'b0, in_flight} < {1'b0, total_len} &&
             in_flight < {19'd0, window} && free_slot[wr_slot]) begin
        off = acked + in_flight;
        len = {19'd0, window} - in_flight;
        if (len > PAYLOAD) len = PAYLOAD;
        if (len > total_len - off) len = total_len - off;
        in_flight           = in_flight + len;
        free_slot[wr_slot]  = 1'b0;
        slot_seq[wr_slot]   = off + len;
        slot_tick[wr_slot]  = ticks;
        wr_slot             = wr_slot + 3'd1;
        push(KIND_SEND, off, len, off + len, (off + len) >= total_len);
      end
    endfunction

    // Predict every result word of one accepted event word.
    function void note_event(code_t op, logic [31:0] ack);
      int base;
      base = expected_words.size();
      if (op == OP_TICK) ticks = ticks + 1;
      if (op == OP_START) begin
        restart();
        phase = PH_SENDING;
        fill_window();
      end else if (phase != PH_SENDING) begin
      end else if (op == OP_TICK) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!free_slot[i] && (ticks - slot_tick[i]) > {16'd0, timeout}) begin
            in_flight = '0;
            for (int j = 0; j < SLOTS; j++) free_slot[j] = 1'b1;
            wr_slot = '0;
            fill_window();
            break;
          end
        end
      end else if (op == OP_ACK) begin
        if ({1'b0, ack} > {1'b0, acked} + {1'b0, in_flight} || ack < prev_ack) begin
          push(KIND_DROPPED, 0, 0, 0, 0);
        end else begin
          for (int i = 0; i < SLOTS; i++)
            if (!free_slot[i] && slot_seq[i] <= ack) free_slot[i] = 1'b1;
          in_flight = in_flight - (ack - prev_ack);
          acked     = ack;
          prev_ack  = ack;
          idle_cnt  = '0;
          push(KIND_ACCEPT, 0, 0, 0, 0);
          if (acked >= total_len && acked != 0 && total_len != 0) begin
            phase = PH_FINISHED;
            push(KIND_DONE, 0, 0, 0, 0);
          end else begin
            fill_window();
          end
        end
      end else if (op == OP_FIN) begin
        phase = PH_FINISHED;
        push(KIND_CLOSED, 0, 0, 0, 0);
      end else if (op == OP_RTO) begin
        idle_cnt = idle_cnt + 16'd1;
        if (idle_cnt == max_idle) begin
          phase = PH_FINISHED;
          push(KIND_GAVE_UP, 0, 0, 0, 0);
        end
      end
      if (expected_words.size() == base) push(KIND_NONE, 0, 0, 0, 0);
      expected_words[expected_words.size()-1].last = 1'b1;
    endfunction

    function void check_result(result_t got);
      result_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result word kind=%0d off=%0d len=%0d",
                   got.kind, got.offset, got.length);
        return;
      end
      exp_w = expected_words.pop_front();
      if (got !== exp_w) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result mismatch exp kind=%0d off=%0d len=%0d seq=%0d eof=%0b last=%0b",
                   exp_w.kind, exp_w.offset, exp_w.length, exp_w.seq, exp_w.eof,
                   exp_w.last);
          $display("       got kind=%0d off=%0d len=%0d seq=%0d eof=%0b last=%0b",
                   got.kind, got.offset, got.length, got.seq, got.eof, got.last);
        end
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [31:0]       cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [2:0]        operation_i;
  logic [31:0]       ack_number_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [2:0]        kind_o;
  logic [31:0]       segment_offset_o;
  logic [10:0]       segment_length_o;
  logic [31:0]       sequence_number_o;
  logic              end_of_file_o;
  logic              last_result_o;

  go_back_n_sender_window #(
    .SLOT_COUNT (SLOTS),
    .MAX_PAYLOAD(PAYLOAD)
  ) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .operation_i      (operation_i),
    .ack_number_i     (ack_number_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .kind_o           (kind_o),
    .segment_offset_o (segment_offset_o),
    .segment_length_o (segment_length_o),
    .sequence_number_o(sequence_number_o),
    .end_of_file_o    (end_of_file_o),
    .last_result_o    (last_result_o)
  );

  segment_scoreboard sb = new();
  bit calm;        // no idling on either side
  int stall_left;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL go_back_n_sender_window");
    $finish;
  end

  // Stall the result channel for a drawn number of cycles after each word.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  = stall_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({kind_o, segment_offset_o, segment_length_o,
                       sequence_number_o, end_of_file_o, last_result_o});
      stall_left = calm ? 0 : $urandom_range(0, 17);
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] total, logic [31:0] win, logic [31:0] tmo,
                           logic [31:0] idle);
    wait_drained();
    write_reg(REG_TOTAL_LENGTH, total);
    write_reg(REG_WINDOW_BYTES, win);
    write_reg(REG_TIMEOUT_TICKS, tmo);
    write_reg(REG_MAX_IDLE, idle);
  endtask

  task automatic send_event(code_t op, logic [31:0] ack);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 17);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    ack_number_i <= ack;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_event(op, ack);
    // drop valid while the block is busy so the word is taken once
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Draw one event word, mostly well formed for the current transfer.
  task automatic random_event();
    int          pick;
    logic [31:0] top;
    pick = $urandom_range(0, 99);
    top  = sb.acked + sb.in_flight;
    if (sb.phase != PH_SENDING && pick < 80) send_event(OP_START, $urandom());
    else if (pick < 40) begin
      if ($urandom_range(0, 2) == 0) send_event(OP_ACK, top);
      else if ($urandom_range(0, 1) == 0 && sb.in_flight != 0)
        send_event(OP_ACK, sb.slot_seq[$urandom_range(0, SLOTS-1)]);
      else send_event(OP_ACK, sb.acked + $urandom_range(0, sb.in_flight));
    end
    else if (pick < 68) send_event(OP_TICK, $urandom());
    else if (pick < 74) send_event(OP_ACK, top + 1 + $urandom_range(0, 3000));
    else if (pick < 78 && sb.prev_ack != 0)
      send_event(OP_ACK, $urandom_range(0, sb.prev_ack - 1));
    else if (pick < 81) send_event(OP_ACK, $urandom());
    else if (pick < 88) send_event(OP_RTO, $urandom());
    else if (pick < 91) send_event(OP_OTHER, $urandom());
    else if (pick < 93) send_event(OP_FIN, $urandom());
    else if (pick < 95) send_event(code_t'($urandom_range(6, 7)), $urandom());
    else send_event(OP_START, $urandom());
  endtask

  initial begin
    logic [31:0] total;
    logic [31:0] win;
    calm         = 1'b0;
    stall_left   = 0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_TICK;
    ack_number_i = '0;
    out_stall_i  = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // idle phase: everything but start and tick is ignored
    send_event(OP_ACK, 32'hFFFF_FFFF);
    send_event(OP_TICK, 0);
    send_event(3'd6, 0);
    send_event(3'd7, 32'h5555_AAAA);
    send_event(OP_START, 0);            // empty message sends nothing
    send_event(OP_RTO, 0);

    configure(3000, 7168, 1, 1);
    send_event(OP_START, 0);
    send_event(OP_ACK, 5000);           // beyond what was sent
    send_event(OP_ACK, 1024);
    send_event(OP_TICK, 0);
    send_event(OP_TICK, 0);             // timed out: resend from acked point
    send_event(OP_OTHER, 0);
    send_event(OP_ACK, 0);              // stale
    send_event(OP_ACK, 3000);           // done
    send_event(OP_RTO, 0);
    send_event(OP_START, 0);
    send_event(OP_RTO, 0);              // gave up
    send_event(OP_START, 0);
    send_event(OP_FIN, 0);

    configure(32'hFFFF_FFFF, 1, 65535, 65535);
    send_event(OP_START, 0);
    send_event(OP_ACK, 1);
    send_event(OP_ACK, 1);              // repeat of the last ack is accepted
    configure(32'hFFFF_FFFF, 7168, 65535, 2);
    send_event(OP_START, 0);
    send_event(OP_RTO, 0);
    send_event(OP_RTO, 0);

    for (int ph = 0; ph < 7; ph++) begin
      case ($urandom_range(0, 5))
        0:       total = 0;
        1:       total = 32'hFFFF_FFFF - $urandom_range(0, 9000);
        default: total = $urandom_range(1, 12000);
      endcase
      case ($urandom_range(0, 3))
        0:       win = 1;
        1:       win = 7168;
        default: win = $urandom_range(1, 7168);
      endcase
      configure(total, win, ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 30),
                ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(1, 8));
      calm = ($urandom_range(0, 3) == 0);
      send_event(OP_START, 0);
      for (int k = 0; k < 26; k++) begin
        if (ph == 3 && k == 15) wait_drained();   // hold off until all words are back
        random_event();
      end
      calm = 1'b0;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
      $display("PASS go_back_n_sender_window");
    end else begin
      $display("FAIL go_back_n_sender_window");
    end
    $finish;
  end

endmodule
